/* hdl/yptcs_pkg.sv */
// shared constants for the y-plane crossing time selector
`default_nettype none
package yptcs_pkg;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH   = 2'd3;
    localparam int REG_WIDTH_RESET  = 2560;
    localparam int REG_LENGTH_RESET = 25600;

    typedef enum logic [1:0] {
        OP_X = 2'd0,
        OP_Z = 2'd1,
        OP_T = 2'd2
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_RUN  = 5'b00100,
        S_TEST = 5'b01000,
        S_PUSH = 5'b10000
    } back_state_t;
endpackage
`default_nettype wire

/* hdl/yptcs_queue.sv */
// two-entry queue between pipeline parts
`default_nettype none
module yptcs_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [W-1:0] wr_data,
    output logic              full,
    input  wire logic         rd_en,
    output logic [W-1:0]      rd_data,
    output logic              empty
);
    logic [W-1:0] mem [2];
    logic [1:0] cnt_reg, cnt_next;
    logic wr_ptr_reg, rd_ptr_reg;
    logic do_wr, do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end
endmodule
`default_nettype wire

/* hdl/yptcs_front.sv */
// per-hit sign tracking and event record builder
`default_nettype none
module yptcs_front #(
    parameter int P = 20,
    parameter int T = 24,
    parameter int RW = 1 + 2 * (3 * P + T)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          hit_valid,
    input  wire logic [P-1:0]  hit_x,
    input  wire logic [P-1:0]  hit_y,
    input  wire logic [P-1:0]  hit_z,
    input  wire logic [T-1:0]  hit_time,
    input  wire logic          last_hit,
    output logic               rec_push,
    output logic [RW-1:0]      rec_data
);
    logic [P-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic [T-1:0] prev_t_reg;
    logic [P-1:0] pair_x_reg, pair_y_reg, pair_z_reg;
    logic [T-1:0] pair_t_reg;
    logic have_prev_reg, latched_reg;

    logic [P-1:0] prev_x_next, prev_y_next, prev_z_next;
    logic [T-1:0] prev_t_next;
    logic [P-1:0] pair_x_next, pair_y_next, pair_z_next;
    logic [T-1:0] pair_t_next;
    logic have_prev_next, latched_next;
    logic y_pos, y_neg, py_pos, py_neg, opposite;

    assign y_neg    = hit_y[P-1];
    assign y_pos    = !hit_y[P-1] && (hit_y != '0);
    assign py_neg   = prev_y_reg[P-1];
    assign py_pos   = !prev_y_reg[P-1] && (prev_y_reg != '0);
    assign opposite = (y_pos && py_neg) || (y_neg && py_pos);

    always_comb
    begin
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        prev_z_next = prev_z_reg;
        prev_t_next = prev_t_reg;
        pair_x_next = pair_x_reg;
        pair_y_next = pair_y_reg;
        pair_z_next = pair_z_reg;
        pair_t_next = pair_t_reg;
        have_prev_next = have_prev_reg;
        latched_next = latched_reg;
        if (!latched_reg)
        begin
            if (have_prev_reg && opposite)
            begin
                pair_x_next = hit_x;
                pair_y_next = hit_y;
                pair_z_next = hit_z;
                pair_t_next = hit_time;
                latched_next = 1'b1;
            end
            else
            begin
                prev_x_next = hit_x;
                prev_y_next = hit_y;
                prev_z_next = hit_z;
                prev_t_next = hit_time;
                have_prev_next = 1'b1;
            end
        end
    end

    assign rec_push = hit_valid && last_hit;
    assign rec_data = {latched_next, prev_x_next, prev_y_next, prev_z_next, prev_t_next,
                       pair_x_next, pair_y_next, pair_z_next, pair_t_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            latched_reg   <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            prev_t_reg    <= '0;
        end
        else if (hit_valid)
        begin
            have_prev_reg <= last_hit ? 1'b0 : have_prev_next;
            latched_reg   <= last_hit ? 1'b0 : latched_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            prev_z_reg    <= prev_z_next;
            prev_t_reg    <= prev_t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_valid)
        begin
            pair_x_reg <= pair_x_next;
            pair_y_reg <= pair_y_next;
            pair_z_reg <= pair_z_next;
            pair_t_reg <= pair_t_next;
        end
    end
endmodule
`default_nettype wire

/* hdl/yptcs_back.sv */
// per-event crossing solver with a shared serial multiply-divide unit
`default_nettype none
module yptcs_back #(
    parameter int P = 20,
    parameter int T = 24,
    parameter int RW = 1 + 2 * (3 * P + T),
    parameter int OW = 2 + T + 2 * P
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [yptcs_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [P-1:0]                      cfg_data,
    input  wire logic                              rec_empty,
    input  wire logic [RW-1:0]                     rec_data,
    output logic                                   rec_pop,
    input  wire logic                              res_full,
    output logic                                   res_push,
    output logic [OW-1:0]                          res_data
);
    localparam int W   = ((P > T) ? P : T) + 1;
    localparam int CNW = $clog2(W);
    localparam int R   = P + 3;
    localparam int CW  = P + 3;
    localparam int EW  = CW + 1;
    localparam logic [CNW-1:0] LAST_STEP = CNW'(W - 1);

    yptcs_pkg::back_state_t state_reg, state_next;
    yptcs_pkg::op_t op_reg;

    logic signed [P-1:0] cen_x_reg, cen_z_reg;
    logic [P-2:0] width_reg, length_reg;

    logic [P-1:0] px_reg, py_reg, pz_reg, qx_reg, qy_reg, qz_reg;
    logic [T-1:0] pt_reg, qt_reg;
    logic found_reg;

    logic signed [P-1:0] bx_reg, bz_reg;
    logic signed [T-1:0] te_reg;
    logic by_neg_reg, dy_neg_reg, dx_neg_reg, dz_neg_reg;
    logic [P-1:0] a_reg;
    logic [P:0] c_reg;
    logic [W-1:0] dx_mag_reg, dz_mag_reg, dtime_reg;

    logic [W-1:0] b_reg;
    logic [R-1:0] r_reg;
    logic [W-1:0] q_reg;
    logic [CNW-1:0] cnt_reg;

    logic signed [CW-1:0] cx_reg, cz_reg;
    logic sel_reg;
    logic signed [T-1:0] dt_reg;

    // load stage values
    logic late_first;
    logic signed [P:0] dx_w, dz_w, dy_w;
    logic signed [T:0] tdiff;
    logic signed [P-1:0] by_w;

    assign late_first = $signed(pt_reg) > $signed(qt_reg);
    assign by_w  = late_first ? $signed(qy_reg) : $signed(py_reg);
    assign dx_w  = $signed({qx_reg[P-1], qx_reg}) - $signed({px_reg[P-1], px_reg});
    assign dz_w  = $signed({qz_reg[P-1], qz_reg}) - $signed({pz_reg[P-1], pz_reg});
    assign dy_w  = $signed({qy_reg[P-1], qy_reg}) - $signed({py_reg[P-1], py_reg});
    assign tdiff = late_first
                 ? $signed({pt_reg[T-1], pt_reg}) - $signed({qt_reg[T-1], qt_reg})
                 : $signed({qt_reg[T-1], qt_reg}) - $signed({pt_reg[T-1], pt_reg});

    // one step: acc = 2*acc + bit*a, kept as q*c + r with r < c
    logic [R-1:0] r_dbl, c2, c1;
    logic [R-1:0] r_step;
    logic [1:0] q_inc;
    logic [W-1:0] q_step;

    assign c1    = R'(c_reg);
    assign c2    = R'({c_reg, 1'b0});
    assign r_dbl = {r_reg[R-2:0], 1'b0} + (b_reg[W-1] ? R'(a_reg) : '0);

    always_comb
    begin
        priority if (r_dbl >= c2)
        begin
            r_step = r_dbl - c2;
            q_inc  = 2'd2;
        end
        else if (r_dbl >= c1)
        begin
            r_step = r_dbl - c1;
            q_inc  = 2'd1;
        end
        else
        begin
            r_step = r_dbl;
            q_inc  = 2'd0;
        end
    end

    assign q_step = {q_reg[W-2:0], 1'b0} + W'(q_inc);

    // coordinate from quotient
    logic signed [CW-1:0] q_signed, base_sel, coord;
    logic coord_neg;
    assign q_signed  = $signed({1'b0, q_step[CW-2:0]});
    assign base_sel  = (op_reg == yptcs_pkg::OP_X)
                     ? CW'(bx_reg) : CW'(bz_reg);
    assign coord_neg = !(by_neg_reg ^ dy_neg_reg ^
                         ((op_reg == yptcs_pkg::OP_X) ? dx_neg_reg : dz_neg_reg));
    assign coord     = coord_neg ? base_sel - q_signed : base_sel + q_signed;

    // time sum and saturation
    logic signed [T+1:0] tsum;
    logic signed [T-1:0] tsat;
    localparam logic signed [T-1:0] T_MAX = {1'b0, {(T-1){1'b1}}};
    localparam logic signed [T-1:0] T_MIN = {1'b1, {(T-1){1'b0}}};
    assign tsum = (T+2)'(te_reg) + $signed({1'b0, q_step[T:0]});
    always_comb
    begin
        if (!tsum[T+1] && (tsum[T:T-1] != 2'b00))
        begin
            tsat = T_MAX;
        end
        else if (tsum[T+1] && (tsum[T:T-1] != 2'b11))
        begin
            tsat = T_MIN;
        end
        else
        begin
            tsat = tsum[T-1:0];
        end
    end

    // region test on unsaturated crossing
    logic signed [EW-1:0] ex, ez;
    logic [EW-1:0] ex_mag, ez_mag;
    logic in_region;
    assign ex     = EW'(cx_reg) - EW'(cen_x_reg);
    assign ez     = EW'(cz_reg) - EW'(cen_z_reg);
    assign ex_mag = ex[EW-1] ? -ex : ex;
    assign ez_mag = ez[EW-1] ? -ez : ez;
    assign in_region = ({ex_mag, 1'b0} < (EW+1)'(width_reg)) &&
                       ({ez_mag, 1'b0} < (EW+1)'(length_reg));

    // output saturation of coordinates
    localparam logic [P-1:0] P_MAX = {1'b0, {(P-1){1'b1}}};
    localparam logic [P-1:0] P_MIN = {1'b1, {(P-1){1'b0}}};
    function automatic logic [P-1:0] sat_pos(input logic [CW-1:0] v);
        logic [P-1:0] res;
        if (!v[CW-1] && (v[CW-2:P-1] != '0))
        begin
            res = P_MAX;
        end
        else if (v[CW-1] && (v[CW-2:P-1] != '1))
        begin
            res = P_MIN;
        end
        else
        begin
            res = v[P-1:0];
        end
        return res;
    endfunction

    assign res_data = {sel_reg, found_reg, dt_reg,
                       found_reg ? sat_pos(cx_reg) : P'(0),
                       found_reg ? sat_pos(cz_reg) : P'(0)};
    assign res_push = (state_reg == yptcs_pkg::S_PUSH);
    assign rec_pop  = (state_reg == yptcs_pkg::S_IDLE) && !rec_empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            yptcs_pkg::S_IDLE: if (!rec_empty) state_next = yptcs_pkg::S_LOAD;
            yptcs_pkg::S_LOAD: state_next = found_reg ? yptcs_pkg::S_RUN : yptcs_pkg::S_PUSH;
            yptcs_pkg::S_RUN:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    unique case (op_reg)
                        yptcs_pkg::OP_X: state_next = yptcs_pkg::S_RUN;
                        yptcs_pkg::OP_Z: state_next = yptcs_pkg::S_TEST;
                        default:         state_next = yptcs_pkg::S_PUSH;
                    endcase
                end
            end
            yptcs_pkg::S_TEST: state_next = in_region ? yptcs_pkg::S_RUN : yptcs_pkg::S_PUSH;
            yptcs_pkg::S_PUSH: if (!res_full) state_next = yptcs_pkg::S_IDLE;
            default:           state_next = yptcs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= yptcs_pkg::S_IDLE;
            cen_x_reg  <= '0;
            cen_z_reg  <= '0;
            width_reg  <= (P-1)'(yptcs_pkg::REG_WIDTH_RESET);
            length_reg <= (P-1)'(yptcs_pkg::REG_LENGTH_RESET);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    yptcs_pkg::REG_CENTER_X: cen_x_reg  <= cfg_data;
                    yptcs_pkg::REG_CENTER_Z: cen_z_reg  <= cfg_data;
                    yptcs_pkg::REG_WIDTH:    width_reg  <= cfg_data[P-2:0];
                    default:                 length_reg <= cfg_data[P-2:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            yptcs_pkg::S_IDLE:
            begin
                {found_reg, px_reg, py_reg, pz_reg, pt_reg,
                 qx_reg, qy_reg, qz_reg, qt_reg} <= rec_data;
            end
            yptcs_pkg::S_LOAD:
            begin
                bx_reg     <= late_first ? qx_reg : px_reg;
                bz_reg     <= late_first ? qz_reg : pz_reg;
                te_reg     <= late_first ? qt_reg : pt_reg;
                by_neg_reg <= by_w[P-1];
                a_reg      <= by_w[P-1] ? P'(-by_w) : P'(by_w);
                dy_neg_reg <= dy_w[P];
                c_reg      <= dy_w[P] ? (P+1)'(-dy_w) : (P+1)'(dy_w);
                dx_neg_reg <= dx_w[P];
                dz_neg_reg <= dz_w[P];
                dx_mag_reg <= W'(dx_w[P] ? (P+1)'(-dx_w) : (P+1)'(dx_w));
                dz_mag_reg <= W'(dz_w[P] ? (P+1)'(-dz_w) : (P+1)'(dz_w));
                dtime_reg  <= W'(unsigned'(tdiff));
                b_reg      <= W'(dx_w[P] ? (P+1)'(-dx_w) : (P+1)'(dx_w));
                op_reg     <= yptcs_pkg::OP_X;
                r_reg      <= '0;
                q_reg      <= '0;
                cnt_reg    <= '0;
                sel_reg    <= 1'b0;
                dt_reg     <= '0;
                cx_reg     <= '0;
                cz_reg     <= '0;
            end
            yptcs_pkg::S_RUN:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    r_reg   <= '0;
                    q_reg   <= '0;
                    cnt_reg <= '0;
                    unique case (op_reg)
                        yptcs_pkg::OP_X:
                        begin
                            cx_reg <= coord;
                            op_reg <= yptcs_pkg::OP_Z;
                            b_reg  <= dz_mag_reg;
                        end
                        yptcs_pkg::OP_Z: cz_reg <= coord;
                        default:         dt_reg <= tsat;
                    endcase
                end
                else
                begin
                    r_reg   <= r_step;
                    q_reg   <= q_step;
                    b_reg   <= {b_reg[W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + CNW'(1);
                end
            end
            yptcs_pkg::S_TEST:
            begin
                sel_reg <= in_region;
                op_reg  <= yptcs_pkg::OP_T;
                b_reg   <= dtime_reg;
            end
            default:
            begin
            end
        endcase
    end

    // remainder stays reduced while the unit runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == yptcs_pkg::S_RUN) |-> (R'(c_reg) > r_reg))
        else $error("remainder not reduced");

    // dx magnitude is consumed before it can be changed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == yptcs_pkg::S_RUN && op_reg == yptcs_pkg::OP_X) |=> $stable(dx_mag_reg))
        else $error("dx magnitude changed during run");

    // a result leaves only when the output queue has room
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_full) |=> (state_reg == yptcs_pkg::S_PUSH))
        else $error("result dropped on full queue");

    // time is only nonzero when selected
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !sel_reg) |-> (dt_reg == '0))
        else $error("time without selection");
endmodule
`default_nettype wire

/* hdl/y_plane_crossing_time_selector_core.sv */
// top level of the y-plane crossing time selector
`default_nettype none
// Hits stream in through push/full and are classified one per cycle, while
// full is low, by the front part, which tracks the y sign and latches the
// first crossing pair. At each last hit an event record enters a two-entry
// queue; the back part solves the crossing with one shared serial
// multiply-divide unit, running it three times (x, z, then time if the point
// is inside the region), one quotient bit per cycle over
// max(POS_BITS, TIME_BITS)+1 steps. An event without a crossing skips the
// unit. Hits of the next events keep flowing while the back part works until
// two event records wait. Results are held in a two-entry queue read by
// empty/pop. The user must write configuration only when the block is idle;
// the block itself does not enforce it.
module y_plane_crossing_time_selector_core #(
    parameter int POS_BITS  = 20,
    parameter int TIME_BITS = 24
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [yptcs_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [POS_BITS-1:0]                cfg_data,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [POS_BITS-1:0]                hit_x,
    input  wire logic [POS_BITS-1:0]                hit_y,
    input  wire logic [POS_BITS-1:0]                hit_z,
    input  wire logic [TIME_BITS-1:0]               hit_time,
    input  wire logic                               last_hit,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic                                    selected,
    output logic                                    crossing_found,
    output logic [TIME_BITS-1:0]                    time_offset,
    output logic [POS_BITS-1:0]                     cross_x,
    output logic [POS_BITS-1:0]                     cross_z
);
    localparam int RW = 1 + 2 * (3 * POS_BITS + TIME_BITS);
    localparam int OW = 2 + TIME_BITS + 2 * POS_BITS;

    logic hit_beat;
    logic rec_push, rec_full, rec_pop, rec_empty;
    logic [RW-1:0] rec_wdata, rec_rdata;
    logic res_push, res_full;
    logic [OW-1:0] res_wdata, res_rdata;

    // input beat stalls only when both event slots are taken
    assign full     = rec_full;
    assign hit_beat = push && !rec_full;

    yptcs_front #(.P(POS_BITS), .T(TIME_BITS), .RW(RW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit_valid (hit_beat),
        .hit_x     (hit_x),
        .hit_y     (hit_y),
        .hit_z     (hit_z),
        .hit_time  (hit_time),
        .last_hit  (last_hit),
        .rec_push  (rec_push),
        .rec_data  (rec_wdata)
    );

    // event records between front and back
    yptcs_queue #(.W(RW)) u_rec_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (rec_wdata),
        .full    (rec_full),
        .rd_en   (rec_pop),
        .rd_data (rec_rdata),
        .empty   (rec_empty)
    );

    yptcs_back #(.P(POS_BITS), .T(TIME_BITS), .RW(RW), .OW(OW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec_empty (rec_empty),
        .rec_data  (rec_rdata),
        .rec_pop   (rec_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata)
    );

    // finished results wait here for the consumer
    yptcs_queue #(.W(OW)) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wdata),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rdata),
        .empty   (empty)
    );

    assign {selected, crossing_found, time_offset, cross_x, cross_z} = res_rdata;
endmodule
`default_nettype wire
